### hdl/vector3_normalizer_assert.svh
// Assertion macros used by the checker file vn_checker.sv.
`ifndef VECTOR3_NORMALIZER_ASSERT_SVH
`define VECTOR3_NORMALIZER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define VN_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vector3_normalizer assertion failed");

// Next-cycle implication, off during reset.
`define VN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vector3_normalizer assertion failed");

// Next-cycle implication that also holds through reset.
`define VN_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vector3_normalizer assertion failed");

`endif

### hdl/vn_pkg.sv
// Shared constants for the vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;
    localparam int OUT_W       = 16;
    localparam int QUO_BITS    = 16;
    localparam int FRAC_SHIFT  = 22;
    localparam int PRE_SHIFT   = FRAC_SHIFT - QUO_BITS;
    localparam int ROOT_SCALE  = 16;
    localparam logic [OUT_W-1:0] Q_ONE = 16'd16384;
endpackage

### hdl/vector3_normalizer.sv
// Throughput: one vector per cycle unless the result side stalls; set by one root bit per
// square-root stage and one quotient bit per divider stage, all stages in one chain.
// A stall on the result side freezes the whole chain; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps
module vector3_normalizer #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [vn_pkg::OUT_W-1:0]   m_unit_x,
    output logic signed [vn_pkg::OUT_W-1:0]   m_unit_y,
    output logic signed [vn_pkg::OUT_W-1:0]   m_unit_z,
    output logic                              m_was_zero
);
    localparam int W      = COMPONENT_WIDTH;
    localparam int SUM_W  = 2 * W;
    localparam int ROOT_W = W + vn_pkg::ROOT_SCALE / 2;
    localparam int TAG_W  = 3 * W + 4;
    localparam int DSTG   = vn_pkg::QUO_BITS + 1;
    localparam int OW     = vn_pkg::OUT_W;

    logic en;
    logic [W-1:0] raw [3];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign raw[0]  = s_vec_x;
    assign raw[1]  = s_vec_y;
    assign raw[2]  = s_vec_z;

    // stage 1: magnitudes and squares
    logic             v1_reg;
    logic [W-1:0]     mag1_reg [3];
    logic             neg1_reg [3];
    logic [SUM_W-1:0] sq1_reg  [3];

    for (genvar i = 0; i < 3; i++) begin : g_sq
        logic [W-1:0] mag;
        assign mag = raw[i][W-1] ? (~raw[i] + W'(1)) : raw[i];
        always_ff @(posedge aclk) begin
            if (en) begin
                mag1_reg[i] <= mag;
                neg1_reg[i] <= raw[i][W-1];
                sq1_reg[i]  <= SUM_W'(mag) * SUM_W'(mag);
            end
        end
    end

    // stage 2: sum of squares
    logic             v2_reg;
    logic [SUM_W-1:0] sum2_reg;
    logic [TAG_W-1:0] tag2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            tag2_reg <= {(sq1_reg[0] | sq1_reg[1] | sq1_reg[2]) == '0,
                         neg1_reg[2], neg1_reg[1], neg1_reg[0],
                         mag1_reg[2], mag1_reg[1], mag1_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    // square root
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [TAG_W-1:0]  sq_tag;

    vn_sqrt_pipe #(
        .SUM_W (SUM_W),
        .TAG_W (TAG_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_sum    (sum2_reg),
        .in_tag    (tag2_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // three dividers side by side; signs, zero flag and valid ride alongside
    logic [vn_pkg::QUO_BITS-1:0] quo [3];
    logic                        ovf [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        vn_div_pipe #(
            .MAG_W  (W),
            .ROOT_W (ROOT_W)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (sq_tag[i*W +: W]),
            .root (sq_root),
            .quo  (quo[i]),
            .ovf  (ovf[i])
        );
    end

    logic       dv_reg   [DSTG];
    logic [3:0] side_reg [DSTG];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= sq_tag[TAG_W-1 -: 4];
            for (int j = 1; j < DSTG; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DSTG; j++) begin
                dv_reg[j] <= 1'b0;
            end
        end else if (en) begin
            dv_reg[0] <= sq_valid;
            for (int j = 1; j < DSTG; j++) begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end
    end

    // output stage: saturate, restore sign, substitute the zero-vector answer
    logic [OW-1:0] unit_next [3];
    logic          zero_in;

    assign zero_in = side_reg[DSTG-1][3];

    for (genvar i = 0; i < 3; i++) begin : g_out
        logic [OW-1:0] mag_q;
        assign mag_q = (ovf[i] || quo[i] > vn_pkg::Q_ONE) ? vn_pkg::Q_ONE : quo[i];
        always_comb begin
            if (zero_in) begin
                unit_next[i] = (i == 0) ? vn_pkg::Q_ONE : '0;
            end else if (side_reg[DSTG-1][i]) begin
                unit_next[i] = ~mag_q + OW'(1);
            end else begin
                unit_next[i] = mag_q;
            end
        end
    end

    logic          m_valid_reg;
    logic [OW-1:0] unit_x_reg;
    logic [OW-1:0] unit_y_reg;
    logic [OW-1:0] unit_z_reg;
    logic          was_zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            unit_x_reg   <= unit_next[0];
            unit_y_reg   <= unit_next[1];
            unit_z_reg   <= unit_next[2];
            was_zero_reg <= zero_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_reg[DSTG-1];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_unit_x   = unit_x_reg;
    assign m_unit_y   = unit_y_reg;
    assign m_unit_z   = unit_z_reg;
    assign m_was_zero = was_zero_reg;
endmodule

### hdl/vn_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root of S * 2^16, one root bit per stage.
`timescale 1ns / 1ps
module vn_sqrt_pipe #(
    parameter int SUM_W = 32,
    parameter int TAG_W = 52
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [SUM_W-1:0]              in_sum,
    input  logic [TAG_W-1:0]              in_tag,
    output logic                          out_valid,
    output logic [SUM_W/2+vn_pkg::ROOT_SCALE/2-1:0] out_root,
    output logic [TAG_W-1:0]              out_tag
);
    localparam int ROOT_W = SUM_W / 2 + vn_pkg::ROOT_SCALE / 2;
    localparam int RAD_W  = 2 * ROOT_W;

    logic [ROOT_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg  [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [ROOT_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [TAG_W-1:0]  tag_in;
        logic              vld_in;
        logic [ROOT_W+1:0] rem_sh;
        logic [ROOT_W+1:0] trial;
        logic [ROOT_W+1:0] rem_next;
        logic              fit;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {in_sum, {vn_pkg::ROOT_SCALE{1'b0}}};
            assign tag_in  = in_tag;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign tag_in  = tag_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // bring in the next two radicand bits and try the next root bit
        assign rem_sh   = {rem_in, rad_in[RAD_W-1-2*k -: 2]};
        assign trial    = {root_in, 2'b01};
        assign fit      = rem_sh >= trial;
        assign rem_next = fit ? rem_sh - trial : rem_sh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next[ROOT_W-1:0];
                root_reg[k] <= {root_in[ROOT_W-2:0], fit};
                rad_reg[k]  <= rad_in;
                tag_reg[k]  <= tag_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];
endmodule

### hdl/vn_div_pipe.sv
// Pipelined restoring divider: (mag * 2^22) / root, one quotient bit per stage.
`timescale 1ns / 1ps
module vn_div_pipe #(
    parameter int MAG_W  = 16,
    parameter int ROOT_W = 24
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [MAG_W-1:0]              mag,
    input  logic [ROOT_W-1:0]             root,
    output logic [vn_pkg::QUO_BITS-1:0]   quo,
    output logic                          ovf
);
    localparam int NSTG = vn_pkg::QUO_BITS;

    logic [ROOT_W-1:0]          rem_reg  [NSTG+1];
    logic [ROOT_W-1:0]          root_reg [NSTG+1];
    logic [NSTG-1:0]            quo_reg  [NSTG+1];
    logic                       ovf_reg  [NSTG+1];
    logic [ROOT_W-1:0]          rem_init;

    // upper part of the dividend; a quotient past 16 bits shows up here
    assign rem_init = ROOT_W'(mag) << vn_pkg::PRE_SHIFT;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= rem_init;
            root_reg[0] <= root;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= rem_init >= root;
        end
    end

    for (genvar j = 1; j <= NSTG; j++) begin : g_stage
        logic [ROOT_W:0] rem_sh;
        logic [ROOT_W:0] rem_next;
        logic            fit;

        assign rem_sh   = {rem_reg[j-1], 1'b0};
        assign fit      = rem_sh >= {1'b0, root_reg[j-1]};
        assign rem_next = fit ? rem_sh - {1'b0, root_reg[j-1]} : rem_sh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next[ROOT_W-1:0];
                root_reg[j] <= root_reg[j-1];
                quo_reg[j]  <= {quo_reg[j-1][NSTG-2:0], fit};
                ovf_reg[j]  <= ovf_reg[j-1];
            end
        end
    end

    assign quo = quo_reg[NSTG];
    assign ovf = ovf_reg[NSTG];
endmodule

### hdl/vn_checker.sv
// Port-level checker for the vector normalizer and its bind.
`timescale 1ns / 1ps
`include "vector3_normalizer_assert.svh"
module vn_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_unit_x,
    input logic signed [15:0] m_unit_y,
    input logic signed [15:0] m_unit_z,
    input logic               m_was_zero
);
    logic [48:0] result_bus;
    logic        zero_answer;
    logic        units_in_range;

    assign result_bus  = {m_unit_x, m_unit_y, m_unit_z, m_was_zero};
    assign zero_answer = m_unit_x == 16'sd16384 && m_unit_y == 16'sd0 && m_unit_z == 16'sd0;
    assign units_in_range = m_unit_x <= 16'sd16384 && m_unit_x >= -16'sd16384 &&
                            m_unit_y <= 16'sd16384 && m_unit_y >= -16'sd16384 &&
                            m_unit_z <= 16'sd16384 && m_unit_z >= -16'sd16384;

    `VN_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(result_bus))
    `VN_ASSERT_NOW(a_zero_answer, aclk, aresetn, m_valid && m_was_zero, zero_answer)
    `VN_ASSERT_NOW(a_unit_range, aclk, aresetn, m_valid, units_in_range)
    `VN_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid || m_ready, s_ready)
    `VN_ASSERT_ALWAYS_NEXT(a_reset_clears, aclk, !aresetn, !m_valid)
endmodule

bind vector3_normalizer vn_checker u_vn_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_unit_x   (m_unit_x),
    .m_unit_y   (m_unit_y),
    .m_unit_z   (m_unit_z),
    .m_was_zero (m_was_zero)
);
